FILE: rtl/pdlz_pkg.sv
// shared types and constants of the palmdoc lz77 record decompressor
// depends on nothing; imported by palmdoc_lz77_decompressor_unit and tb_top

package pdlz_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 2048;
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned LIMIT_W          = 16;
  localparam logic [15:0] OUT_LIMIT_RST    = 16'd4096;

  // register index of out_limit
  localparam logic REG_OUT_LIMIT = 1'b0;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIST  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  // token decode constants
  localparam logic [7:0] TOK_LIT_RUN_MAX = 8'h08;
  localparam logic [7:0] TOK_PAIR_LO     = 8'h80;
  localparam logic [7:0] TOK_SPACE_LO    = 8'hc0;
  localparam logic [7:0] SPACE_CHAR      = 8'h20;
  localparam logic [3:0] COPY_LEN_BASE   = 4'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_out;
    logic [1:0] status;
  } out_item_t;

endpackage

FILE: rtl/palmdoc_lz77_decompressor_unit.sv
// palmdoc lz77 record decompressor, top level
// holds the token decoder, history memory and result register; uses pdlz_pkg

// One compressed byte is taken per input transfer and decoded bytes leave one per
// output transfer. A plain literal (token 0 or 9..0x7f) or a byte inside a literal
// run gives one byte through S_EMIT; a space pair (0xc0..0xff) gives a space and a
// byte through S_EMIT; a run header (1..8) or the first byte of a back-reference
// gives none. The second byte of a back-reference copies 3..10 bytes from the
// 2048-byte history, each through S_READ then S_EMIT, set by the single history
// memory: each byte is read in S_READ and written back with its output transfer
// in S_EMIT, so copies that overlap their own output see the byte just written. A
// back-reference with a bad distance needs no reads and uses S_EMIT only. A dropped
// byte still passes S_EMIT, a status-only closing item passes S_FINAL, and output
// stall holds S_EMIT or S_FINAL. No new input byte is taken until the last is done.
// A back-reference whose distance is zero or larger than the bytes produced in
// the record gives zeros with status 1. Once out_limit bytes are produced, more
// bytes are dropped and the record's final status becomes 3. A record that ends
// in the middle of a token reports status 2. The final item of a record carries
// last_out and the highest status of the record; when the last input byte yields
// no data byte, a status-only item (byte_valid low) closes the record. All
// record state clears after it, without a clearing pass: a valid distance only
// reaches bytes written in the same record. out_limit (reset 4096) is written via apb
// address 0; the user must do so only while the block is idle, which it does not enforce.

module palmdoc_lz77_decompressor_unit #(
  parameter int unsigned WINDOW_DEPTH = pdlz_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // compressed byte channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdlz_pkg::in_item_t                  in_data,
  // decoded byte channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output pdlz_pkg::out_item_t                 out_data,
  // apb register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdlz_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pdlz_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pdlz_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import pdlz_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_FINAL
  } state_t;

  // how the bytes of one step are formed
  typedef enum logic [1:0] {
    M_LIT,
    M_SPACE,
    M_COPY,
    M_BAD
  } mode_t;

  function automatic logic [1:0] st_max(input logic [1:0] a, input logic [1:0] b);
    st_max = (a > b) ? a : b;
  endfunction

  // history ring, one write and one read port
  logic [7:0] hist_mem [WINDOW_DEPTH];
  logic [7:0] rd_data_r;

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   dist_r, dist_nxt;
  logic [15:0]     prod_r, prod_nxt;
  logic [15:0]     limit_r, limit_nxt;
  logic [3:0]      lit_pend_r, lit_pend_nxt;
  logic            pair_pend_r, pair_pend_nxt;
  logic [5:0]      pair_hi_r, pair_hi_nxt;
  logic [1:0]      err_r, err_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [7:0]      val_r, val_nxt;
  logic            last_r, last_nxt;
  logic            emitted_r, emitted_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // input side
  logic            in_fire;
  logic [7:0]      tok;
  logic [13:0]     code;
  logic [AW-1:0]   code_dist;
  logic [3:0]      code_len;
  logic            code_bad;
  logic            tok_run, tok_lit, tok_space, tok_pair;
  logic [3:0]      post_lit;
  logic            post_pair;

  // emit side
  logic            out_free;
  logic            drop;
  logic            hit_limit;
  logic            final_item;
  logic [7:0]      emit_byte;
  logic            mem_we;
  logic [AW-1:0]   rd_addr;

  // apb write
  logic            cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_OUT_LIMIT);
  assign prdata   = (paddr[CFG_ADDR_W-1] == REG_OUT_LIMIT) ?
                    {{(CFG_DATA_W-LIMIT_W){1'b0}}, limit_r} : '0;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // token classification
  assign tok       = in_data.in_byte;
  assign code      = {pair_hi_r, tok};
  assign code_dist = code[13:3];
  assign code_len  = {1'b0, code[2:0]} + COPY_LEN_BASE;
  assign code_bad  = (code_dist == '0) || ({{(16-AW){1'b0}}, code_dist} > prod_r);
  assign tok_run   = (tok != 8'h00) && (tok <= TOK_LIT_RUN_MAX);
  assign tok_lit   = !tok_run && (tok < TOK_PAIR_LO);
  assign tok_space = (tok >= TOK_SPACE_LO);
  assign tok_pair  = !tok_lit && !tok_run && !tok_space;

  // pending state left behind by this byte, for the truncation check
  always_comb begin
    post_lit  = 4'd0;
    post_pair = 1'b0;
    if (lit_pend_r != 4'd0) begin
      post_lit = lit_pend_r - 4'd1;
    end else if (!pair_pend_r) begin
      if (tok_run) begin
        post_lit = tok[3:0];
      end
      post_pair = tok_pair;
    end
  end

  // per-byte emit decisions
  assign drop      = (prod_r >= limit_r);
  assign hit_limit = ({1'b0, prod_r} + 17'd1) >= {1'b0, limit_r};
  // this byte is the last one shown if the record's last step ends here or the limit cuts it
  assign final_item = last_r && ((cnt_r == 4'd1) || hit_limit);
  assign rd_addr    = wp_r - dist_r;
  assign mem_we     = (state_r == S_EMIT) && out_free && !drop;

  always_comb begin
    unique case (mode_r)
      M_LIT:   emit_byte = val_r;
      M_SPACE: emit_byte = (cnt_r == 4'd2) ? SPACE_CHAR : val_r;
      M_COPY:  emit_byte = rd_data_r;
      M_BAD:   emit_byte = 8'h00;
      default: emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    wp_nxt        = wp_r;
    dist_nxt      = dist_r;
    prod_nxt      = prod_r;
    limit_nxt     = limit_r;
    lit_pend_nxt  = lit_pend_r;
    pair_pend_nxt = pair_pend_r;
    pair_hi_nxt   = pair_hi_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      limit_nxt = pwdata[LIMIT_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt    = in_data.last_in;
          emitted_nxt = 1'b0;
          val_nxt     = tok;
          dist_nxt    = code_dist;
          cnt_nxt     = 4'd0;
          mode_nxt    = M_LIT;
          if (lit_pend_r != 4'd0) begin
            cnt_nxt      = 4'd1;
            lit_pend_nxt = lit_pend_r - 4'd1;
          end else if (pair_pend_r) begin
            cnt_nxt       = code_len;
            mode_nxt      = code_bad ? M_BAD : M_COPY;
            pair_pend_nxt = 1'b0;
            pair_hi_nxt   = 6'd0;
            if (code_bad) begin
              err_nxt = st_max(err_nxt, ST_BAD_DIST);
            end
          end else if (tok_run) begin
            lit_pend_nxt = tok[3:0];
          end else if (tok_lit) begin
            cnt_nxt = 4'd1;
          end else if (tok_space) begin
            cnt_nxt  = 4'd2;
            mode_nxt = M_SPACE;
            val_nxt  = tok ^ TOK_PAIR_LO;
          end else begin
            pair_pend_nxt = 1'b1;
            pair_hi_nxt   = tok[5:0];
          end
          if (in_data.last_in) begin
            if ((post_lit != 4'd0) || post_pair) begin
              err_nxt = st_max(err_nxt, ST_TRUNCATED);
            end
            // pending token state is not needed past the record end
            lit_pend_nxt  = 4'd0;
            pair_pend_nxt = 1'b0;
            pair_hi_nxt   = 6'd0;
          end
          if (cnt_nxt != 4'd0) begin
            state_nxt = (mode_nxt == M_COPY) ? S_READ : S_EMIT;
          end else if (in_data.last_in) begin
            state_nxt = S_FINAL;
          end
        end
      end

      S_READ: begin
        // history byte lands in rd_data_r
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          cnt_nxt = cnt_r - 4'd1;
          if (drop) begin
            err_nxt = st_max(err_r, ST_LIMIT);
          end else begin
            wp_nxt                  = wp_r + 1'b1;
            prod_nxt                = prod_r + 16'd1;
            emitted_nxt             = 1'b1;
            out_valid_nxt           = 1'b1;
            out_data_nxt.out_byte   = emit_byte;
            out_data_nxt.byte_valid = 1'b1;
            out_data_nxt.last_out   = final_item;
            if (final_item) begin
              out_data_nxt.status = ((cnt_r != 4'd1) && hit_limit) ?
                                    st_max(err_r, ST_LIMIT) : err_r;
            end else begin
              out_data_nxt.status = (mode_r == M_BAD) ? ST_BAD_DIST : ST_OK;
            end
          end
          if (cnt_r == 4'd1) begin
            if (!last_r) begin
              state_nxt = S_IDLE;
            end else if (emitted_r || !drop) begin
              // record closed by this data byte
              state_nxt   = S_IDLE;
              wp_nxt      = '0;
              prod_nxt    = 16'd0;
              err_nxt     = ST_OK;
              emitted_nxt = 1'b0;
            end else begin
              state_nxt = S_FINAL;
            end
          end else begin
            state_nxt = (mode_r == M_COPY) ? S_READ : S_EMIT;
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_byte   = 8'h00;
          out_data_nxt.byte_valid = 1'b0;
          out_data_nxt.last_out   = 1'b1;
          out_data_nxt.status     = err_r;
          state_nxt               = S_IDLE;
          wp_nxt                  = '0;
          prod_nxt                = 16'd0;
          err_nxt                 = ST_OK;
          emitted_nxt             = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      prod_r      <= 16'd0;
      limit_r     <= OUT_LIMIT_RST;
      lit_pend_r  <= 4'd0;
      pair_pend_r <= 1'b0;
      pair_hi_r   <= 6'd0;
      err_r       <= ST_OK;
      cnt_r       <= 4'd0;
      last_r      <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      limit_r     <= limit_nxt;
      lit_pend_r  <= lit_pend_nxt;
      pair_pend_r <= pair_pend_nxt;
      pair_hi_r   <= pair_hi_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset needed
    mode_r     <= mode_nxt;
    dist_r     <= dist_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  // history memory: write with the output transfer, registered read in S_READ ahead of it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= emit_byte;
    end
    if (state_r == S_READ) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for palmdoc_lz77_decompressor_unit
// decodes each compressed byte in its own decoder copy and checks every decoded byte transfer
// depends on pdlz_pkg and the rtl of the decompressor only

`timescale 1ns / 1ps

module tb_top;
  import pdlz_pkg::*;

  localparam int unsigned WINDOW = WINDOW_DEPTH_DEF;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_OUT_LIMIT, 2'b00};
  // cycles the block may still be busy after the last decoded byte left
  localparam int SETTLE_CYCLES = 40;
  // receiver hold-off of the backpressure test, in cycles
  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  palmdoc_lz77_decompressor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decoder copy: history ring and per-record token state
  // ---------------------------------------------------------------------------
  logic [7:0]  hist_mem [WINDOW];
  logic [10:0] wr_ptr;
  int unsigned prod_cnt;
  int unsigned lit_left;
  bit          pair_wait;
  logic [5:0]  pair_hi;
  logic [1:0]  rec_status;
  logic [15:0] limit_reg = OUT_LIMIT_RST;

  out_item_t   step_q[$];      // decoded bytes of the byte being decoded
  out_item_t   expected_q[$];  // decoded bytes still owed by the block
  logic [7:0]  rec_q[$];       // compressed record being built
  int          items_sent;
  int          error_count;

  // stimulus knobs, written by the test tasks
  int          send_idle_pct;
  int          stall_pct;
  int          hold_reqs;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic void raise_status(input logic [1:0] code);
    if (code > rec_status) rec_status = code;
  endfunction

  function automatic void clear_record_state();
    hist_mem   = '{default: '0};
    wr_ptr     = '0;
    prod_cnt   = 0;
    lit_left   = 0;
    pair_wait  = 1'b0;
    pair_hi    = '0;
    rec_status = ST_OK;
  endfunction

  // one decoded byte, dropped once the record hit its output limit
  function automatic void emit_byte(input logic [7:0] v, input logic [1:0] st);
    if (prod_cnt >= limit_reg) begin
      raise_status(ST_LIMIT);
      return;
    end
    hist_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + 11'd1;
    prod_cnt++;
    step_q.push_back('{out_byte: v, byte_valid: 1'b1, last_out: 1'b0, status: st});
  endfunction

  // decodes one compressed byte and queues the decoded bytes it owes
  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    logic [13:0] code;
    int unsigned copy_dist;
    int unsigned len;
    bit          bad;
    out_item_t   tail;
    step_q.delete();
    if (lit_left != 0) begin
      emit_byte(b, ST_OK);
      lit_left--;
    end else if (pair_wait) begin
      code = {pair_hi, b};
      copy_dist = code[13:3];
      len  = code[2:0] + COPY_LEN_BASE;
      bad  = (copy_dist == 0) || (copy_dist > prod_cnt);
      pair_wait = 1'b0;
      pair_hi   = '0;
      if (bad) raise_status(ST_BAD_DIST);
      // byte by byte, so a copy that overlaps its own output repeats it
      repeat (len) begin
        if (bad) emit_byte(8'h00, ST_BAD_DIST);
        else emit_byte(hist_mem[wr_ptr - 11'(copy_dist)], ST_OK);
      end
    end else if (b != 8'h00 && b <= TOK_LIT_RUN_MAX) begin
      lit_left = b;
    end else if (b < TOK_PAIR_LO) begin
      emit_byte(b, ST_OK);
    end else if (b >= TOK_SPACE_LO) begin
      emit_byte(SPACE_CHAR, ST_OK);
      emit_byte(b ^ TOK_PAIR_LO, ST_OK);
    end else begin
      pair_wait = 1'b1;
      pair_hi   = b[5:0];
    end
    if (lst) begin
      // a run or pair cut off by the record end
      if (lit_left != 0 || pair_wait) raise_status(ST_TRUNCATED);
      if (step_q.size() == 0) begin
        step_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0, last_out: 1'b1,
                           status: rec_status});
      end else begin
        tail = step_q.pop_back();
        tail.last_out = 1'b1;
        tail.status   = rec_status;
        step_q.push_back(tail);
      end
      clear_record_state();
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // every decoded byte transfer is matched against the oldest owed byte
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, nothing owed,", $time,
                 " got byte %h valid %b last %b status %0d",
                 out_data.out_byte, out_data.byte_valid, out_data.last_out,
                 out_data.status);
      end else begin
        want = expected_q.pop_front();
        if (out_data !== want) begin
          error_count++;
          $display("%0t: result error, expected byte %h valid %b last %b status %0d,",
                   $time, want.out_byte, want.byte_valid, want.last_out, want.status,
                   " got byte %h valid %b last %b status %0d",
                   out_data.out_byte, out_data.byte_valid, out_data.last_out,
                   out_data.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared tasks; each is entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // offers one compressed byte; valid stays high into the next transfer unless
  // an idle gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, last_in: lst};
    do @(posedge clk); while (in_stall);
    decode_byte(b, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_record();
    foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
  endtask

  // waits until every owed byte left, then lets a trailing copy finish
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of out_limit, then a read back of it
  task automatic set_out_limit(input logic [15:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_reg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LIMIT_W-1:0] !== v) begin
      error_count++;
      $display("%0t: out_limit read back error, expected %h, got %h",
               $time, v, prdata[LIMIT_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // builds a mostly well-formed record: literals, runs, space pairs and
  // back-references that reach only bytes already decoded, with some noise
  // bytes, bad distances and a token cut off at the end now and then
  task automatic build_record(input int max_tokens);
    int          pick;
    int          n;
    int          est;
    int          copy_dist;
    logic [2:0]  len;
    logic [13:0] code;
    rec_q.delete();
    est = 0;
    repeat ($urandom_range(max_tokens, 1)) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        rec_q.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(8'h7f, 9)));
        est++;
      end else if (pick < 40) begin
        n = $urandom_range(TOK_LIT_RUN_MAX, 1);
        rec_q.push_back(8'(n));
        repeat (n) rec_q.push_back(8'($urandom_range(255)));
        est += n;
      end else if (pick < 60) begin
        rec_q.push_back(8'($urandom_range(8'hff, TOK_SPACE_LO)));
        est += 2;
      end else if (pick >= 88 && pick < 94) begin
        rec_q.push_back(8'($urandom_range(255)));
        est++;
      end else begin
        if (pick < 88 && est > 0) begin
          // short distances overlap the copy with its own output
          if ($urandom_range(1) == 0) copy_dist = $urandom_range(est < 8 ? est : 8, 1);
          else copy_dist = $urandom_range(est < 2047 ? est : 2047, 1);
        end else if (est >= 2047 || $urandom_range(1) == 0) begin
          copy_dist = 0;
        end else begin
          copy_dist = $urandom_range(2047, est + 1);
        end
        len  = 3'($urandom_range(7));
        code = {11'(copy_dist), len};
        rec_q.push_back({2'b10, code[13:8]});
        rec_q.push_back(code[7:0]);
        est += len + COPY_LEN_BASE;
      end
    end
    if ($urandom_range(5) == 0) begin
      if ($urandom_range(1) == 0) begin
        rec_q.push_back({2'b10, 6'($urandom_range(63))});
      end else begin
        n = $urandom_range(TOK_LIT_RUN_MAX, 1);
        rec_q.push_back(8'(n));
        repeat ($urandom_range(n - 1)) rec_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every token kind, field extremes, bad distances and cut-off tokens
  task automatic test_token_kinds();
    send_idle_pct = 0;
    stall_pct     = 0;
    // literals 0, 0x7f, 9, 'A'; space pairs at both ends; run of 3 with
    // extreme bytes; overlapping copy of 10 at distance 1; distance 2047
    // beyond the record; distance 0; run header as last byte
    rec_q = '{8'h00, 8'h7f, 8'h09, 8'h41, 8'hc0, 8'hff, 8'h03, 8'h80, 8'hff, 8'h00,
              8'h80, 8'h0f, 8'hbf, 8'hf8, 8'h80, 8'h00, 8'h08};
    send_record();
    // pair token cut off by the record end
    rec_q = '{8'hbf};
    send_record();
    // run cut off after one byte, last byte still decoded
    rec_q = '{8'h05, 8'h01};
    send_record();
    // clean single literal record
    rec_q = '{8'h41};
    send_record();
    // copy of 3 at distance 1 closing the record
    rec_q = '{8'h09, 8'h80, 8'h08};
    send_record();
  endtask

  // output limit of zero and one, and a limit inside a copy
  task automatic test_out_limit();
    set_out_limit(16'd1);
    rec_q = '{8'h41, 8'hc1};
    send_record();
    set_out_limit(16'd5);
    rec_q = '{8'h03, 8'h61, 8'h62, 8'h63, 8'h80, 8'h0f};
    send_record();
    // zero limit drops everything
    set_out_limit(16'd0);
    rec_q = '{8'h41};
    send_record();
  endtask

  task automatic test_random_records(input int send_pct, input int rcv_pct,
                                     input logic [15:0] lim, input int budget);
    int start;
    set_out_limit(lim);
    send_idle_pct = send_pct;
    stall_pct     = rcv_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      build_record(12);
      send_record();
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the
  // block backs up and stalls its input
  task automatic test_backpressure();
    set_out_limit(16'hffff);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs++;
    build_record(20);
    send_record();
    build_record(8);
    send_record();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent    = 0;
    error_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    clear_record_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_token_kinds();
    test_out_limit();
    test_random_records(0, 0, 16'hffff, 90);
    test_random_records(76, 0, 16'($urandom_range(40, 4)), 90);
    test_random_records(0, 76, OUT_LIMIT_RST, 90);
    test_random_records(14, 14, 16'($urandom_range(300, 20)), 90);
    test_backpressure();

    drain();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/pdlz_pkg.sv
rtl/palmdoc_lz77_decompressor_unit.sv
dv/tb_top.sv
